/* rtl/core/hpool_pkg.sv */
// Shared types and constants for the handle pool core.
`default_nettype none

package hpool_pkg;

    // Field widths
    localparam int unsigned HANDLE_W      = 8;
    localparam int unsigned COUNT_W       = 9;
    localparam int unsigned KIND_W        = 2;
    localparam int unsigned POOL_SIZE_DEF = 256;

    // Request kind codes on the input side
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Decoded operation, one-hot
    typedef enum logic [3:0] {
        OP_ALLOC = 4'b0001,
        OP_TRY   = 4'b0010,
        OP_REL   = 4'b0100,
        OP_NOP   = 4'b1000
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_INVALID   = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [COUNT_W-1:0]  released;
        logic [COUNT_W-1:0]  live;
        status_t             status;
        logic [HANDLE_W-1:0] handle;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/fifo_free_list_handle_pool_core.sv */
// Top level of the handle pool: front decode, command queue, back executor.
// A request passes through a command queue entry, the back end's fetch and execute states
// (around the registered read of the free-list memory) and the result register before it
// shows on m_tvalid. The back end takes no new request until the last one is committed.
// Reset: rst_n clears pointers, counts, the live bitmap and all valid flags at once;
// the free-list memory is not cleared and there is no clearing pass.
`default_nettype none

module fifo_free_list_handle_pool_core #(
    parameter int unsigned POOL_SIZE = hpool_pkg::POOL_SIZE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] handle_in
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [7:0] handle_out, [9:8] status,
                                        // [18:10] live_count, [27:19] released_count
);
    import hpool_pkg::*;

    logic    f_valid;
    logic    f_ready;
    cmd_t    f_cmd;
    logic    b_valid;
    logic    b_ready;
    cmd_t    b_cmd;
    result_t result;

    hpool_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    hpool_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    hpool_back #(
        .POOL_SIZE (POOL_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd        (b_cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Result packing, zero padded to 32 bits
    assign m_tdata = {4'b0000, result.released, result.live, result.status, result.handle};

endmodule

`default_nettype wire

/* rtl/core/hpool_front.sv */
// Front end: takes requests from the input stream and decodes their kind.
`default_nettype none

module hpool_front (
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [hpool_pkg::HANDLE_W-1:0]      s_tdata,
    input  wire logic [hpool_pkg::KIND_W-1:0]        s_tuser,
    output logic                                     cmd_valid,
    input  wire logic                                cmd_ready,
    output hpool_pkg::cmd_t                          cmd
);
    import hpool_pkg::*;

    // Kind decode; unused code becomes a no-op
    always_comb
    begin
        cmd.handle = s_tdata;
        unique case (s_tuser)
            KIND_ALLOC:   cmd.op = OP_ALLOC;
            KIND_TRY:     cmd.op = OP_TRY;
            KIND_RELEASE: cmd.op = OP_REL;
            default:      cmd.op = OP_NOP;
        endcase
    end

    // Flow control follows the command queue
    assign cmd_valid = s_tvalid;
    assign s_tready  = cmd_ready;

endmodule

`default_nettype wire

/* rtl/core/hpool_cmdq.sv */
// Two-entry command queue between the front and back ends.
`default_nettype none

module hpool_cmdq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  hpool_pkg::cmd_t      in_cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output hpool_pkg::cmd_t      out_cmd
);
    import hpool_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/hpool_back.sv */
// Back end: free-list memory, live bitmap, counters and the result register.
`default_nettype none

module hpool_back #(
    parameter int unsigned POOL_SIZE = hpool_pkg::POOL_SIZE_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  hpool_pkg::cmd_t      cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output hpool_pkg::result_t   out_result
);
    import hpool_pkg::*;

    // Only handles below 256 can come back, so queue and bitmap stop there
    localparam int unsigned QD  = (POOL_SIZE < 256) ? POOL_SIZE : 256;
    localparam int unsigned QAW = $clog2(QD);
    localparam int unsigned MW  = $clog2(POOL_SIZE + 1);

    typedef enum logic [1:0] {
        B_FETCH = 2'b01,
        B_EXEC  = 2'b10
    } bstate_t;

    bstate_t              state_reg;
    bstate_t              state_next;
    cmd_t                 cur_reg;
    cmd_t                 cur_next;
    logic [HANDLE_W-1:0]  fq_mem [QD];
    logic [HANDLE_W-1:0]  rd_data_reg;
    logic [QAW-1:0]       head_reg;
    logic [QAW-1:0]       head_next;
    logic [QAW-1:0]       tail_reg;
    logic [QAW-1:0]       tail_next;
    logic [COUNT_W-1:0]   fill_reg;
    logic [COUNT_W-1:0]   fill_next;
    logic [COUNT_W-1:0]   live_reg;
    logic [COUNT_W-1:0]   live_next;
    logic [MW-1:0]        minted_reg;
    logic [MW-1:0]        minted_next;
    logic [QD-1:0]        live_map_reg;
    logic                 out_valid_reg;
    result_t              out_result_reg;
    logic [HANDLE_W-1:0]  res_handle;
    status_t              res_status;
    logic                 out_free;
    logic                 commit;
    logic                 do_pop;
    logic                 do_mint;
    logic                 do_rel;
    logic                 do_push;
    logic                 rel_in_pool;
    logic                 can_mint;
    logic                 mint_in_map;
    logic [QAW-1:0]       rel_idx;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // Fetch / execute sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cmd_ready  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            B_FETCH:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next   = cmd;
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = B_FETCH;
                end
            end
            default: state_next = B_FETCH;
        endcase
    end

    // Request decision
    assign rel_in_pool = ({{(32-HANDLE_W){1'b0}}, cur_reg.handle} < 32'(POOL_SIZE));
    assign rel_idx     = cur_reg.handle[QAW-1:0];
    assign can_mint    = (minted_reg < MW'(POOL_SIZE));
    assign mint_in_map = (minted_reg < MW'(QD));

    always_comb
    begin
        do_pop     = 1'b0;
        do_mint    = 1'b0;
        do_rel     = 1'b0;
        res_handle = '0;
        res_status = ST_OK;
        unique case (cur_reg.op)
            OP_ALLOC, OP_TRY:
            begin
                if (fill_reg != '0)
                begin
                    do_pop     = 1'b1;
                    res_handle = rd_data_reg;
                end
                else if (cur_reg.op == OP_TRY)
                begin
                    res_status = ST_EMPTY;
                end
                else if (can_mint)
                begin
                    do_mint    = 1'b1;
                    res_handle = HANDLE_W'(minted_reg);
                end
                else
                begin
                    res_status = ST_EXHAUSTED;
                end
            end
            OP_REL:
            begin
                if (!rel_in_pool || !live_map_reg[rel_idx])
                begin
                    res_status = ST_INVALID;
                end
                else
                begin
                    do_rel = 1'b1;
                end
            end
            default: res_status = ST_OK;
        endcase
        do_push = do_rel && (fill_reg < COUNT_W'(QD));
    end

    // Counter and pointer updates on commit
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        live_next   = live_reg;
        minted_next = minted_reg;
        if (commit)
        begin
            if (do_pop)
            begin
                head_next = (head_reg == QAW'(QD - 1)) ? '0 : head_reg + 1'b1;
                fill_next = fill_reg - 1'b1;
                live_next = live_reg + 1'b1;
            end
            if (do_mint)
            begin
                minted_next = minted_reg + 1'b1;
                live_next   = live_reg + 1'b1;
            end
            if (do_rel)
            begin
                live_next = live_reg - 1'b1;
            end
            if (do_push)
            begin
                tail_next = (tail_reg == QAW'(QD - 1)) ? '0 : tail_reg + 1'b1;
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_FETCH;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            live_reg      <= '0;
            minted_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            live_reg   <= live_next;
            minted_reg <= minted_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Live bitmap: set on grant, cleared on good release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_map_reg <= '0;
        end
        else if (commit)
        begin
            if (do_pop)
            begin
                live_map_reg[rd_data_reg[QAW-1:0]] <= 1'b1;
            end
            if (do_mint && mint_in_map)
            begin
                live_map_reg[minted_reg[QAW-1:0]] <= 1'b1;
            end
            if (do_rel)
            begin
                live_map_reg[rel_idx] <= 1'b0;
            end
        end
    end

    // Payload registers; counts in the result are the post-update values
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (commit)
        begin
            out_result_reg <= '{released: fill_next, live: live_next,
                                status: res_status, handle: res_handle};
        end
    end

    // Free-list memory, head slot read every cycle
    always_ff @(posedge clk)
    begin
        if (commit && do_push)
        begin
            fq_mem[tail_reg] <= cur_reg.handle;
        end
        rd_data_reg <= fq_mem[head_reg];
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_W'(QD))
        else $error("free list fill beyond capacity");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        commit && do_pop |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("pop did not reduce fill");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.status != ST_OK |-> out_result_reg.handle == '0)
        else $error("failed request returned a handle");
`endif

endmodule

`default_nettype wire

/* verif/handle_pool_checker.sv */
// Checker for the handle pool: predicts each result and compares it with the output stream.
`default_nettype none

module handle_pool_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] handle_in
    input  wire logic [1:0]                          s_tuser,   // [1:0] kind
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [31:0]                         m_tdata,   // [7:0] handle_out,
                                                                // [9:8] status,
                                                                // [18:10] live_count,
                                                                // [27:19] released_count
    output int                                       mismatches,
    output int                                       outstanding,
    output logic [hpool_pkg::POOL_SIZE_DEF-1:0]      live_handles
);
    import hpool_pkg::*;

    localparam int POOL = POOL_SIZE_DEF;

    // Shadow pool: ring of released handles plus mint and live counters
    logic [HANDLE_W-1:0] free_ring [POOL];
    int                  ring_head;
    int                  ring_tail;
    int                  ring_fill;
    int                  minted;
    int                  live_total;
    result_t             pending_results [$];

    // Apply one request to the shadow pool and return the result it should produce
    function automatic result_t apply_request(logic [KIND_W-1:0] kind,
                                              logic [HANDLE_W-1:0] hin);
        result_t r;
        r        = '0;
        r.status = ST_OK;
        if (kind == KIND_ALLOC || kind == KIND_TRY)
        begin
            if (ring_fill > 0)
            begin
                // reuse the oldest released handle
                r.handle  = free_ring[ring_head];
                ring_head = (ring_head + 1) % POOL;
                ring_fill--;
                live_handles[r.handle] = 1'b1;
                live_total++;
            end
            else if (kind == KIND_TRY)
            begin
                r.status = ST_EMPTY;
            end
            else if (minted < POOL)
            begin
                r.handle = HANDLE_W'(minted);
                minted++;
                live_handles[r.handle] = 1'b1;
                live_total++;
            end
            else
            begin
                r.status = ST_EXHAUSTED;
            end
        end
        else if (kind == KIND_RELEASE)
        begin
            if (int'(hin) >= POOL || !live_handles[hin])
            begin
                r.status = ST_INVALID;
            end
            else
            begin
                live_handles[hin] = 1'b0;
                live_total--;
                // a full ring cannot occur, but a push into one is dropped
                if (ring_fill < POOL)
                begin
                    free_ring[ring_tail] = hin;
                    ring_tail = (ring_tail + 1) % POOL;
                    ring_fill++;
                end
            end
        end
        // unused kind: state untouched, ok status with zero handle
        r.live     = COUNT_W'(live_total);
        r.released = COUNT_W'(ring_fill);
        return r;
    endfunction

    // Compare results first, then predict for the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            ring_head    = 0;
            ring_tail    = 0;
            ring_fill    = 0;
            minted       = 0;
            live_total   = 0;
            live_handles = '0;
            mismatches   = 0;
            outstanding  = 0;
            pending_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: handle %0d status %0d %s %0d %s %0d",
                                 $realtime, got.handle, got.status,
                                 "live", got.live, "released", got.released);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.handle != want.handle || got.status != want.status ||
                        got.live != want.live || got.released != want.released)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("    expected: handle %0d status %0d live %0d released %0d",
                                     want.handle, want.status, want.live, want.released);
                            $display("    actual:   handle %0d status %0d live %0d released %0d",
                                     got.handle, got.status, got.live, got.released);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_request(s_tuser, s_tdata));
            outstanding = pending_results.size();
        end
    end

endmodule

`default_nettype wire

/* verif/fifo_free_list_handle_pool_core_test.sv */
// Testbench top for the handle pool core: clock, reset, request stimulus and verdict.
`default_nettype none

module fifo_free_list_handle_pool_core_test;

    import hpool_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_GAP     = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;   // [7:0] handle_in
    logic [1:0]               s_tuser;   // [1:0] kind
    logic                     m_tvalid;
    logic                     m_tready;
    logic [31:0]              m_tdata;   // [7:0] handle_out, [9:8] status,
                                         // [18:10] live_count, [27:19] released_count
    int                       mismatches;
    int                       outstanding;
    logic [POOL_SIZE_DEF-1:0] live_handles;

    bit                       steady_flow;
    int                       hold_asked;
    int                       hold_served;
    int                       idle_cycles;
    int                       sent_by_kind [4];

    fifo_free_list_handle_pool_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    handle_pool_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .live_handles (live_handles)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: give up after a long stretch with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: random stalls per result, plus one long hold-off on demand
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_asked != hold_served)
            begin
                gap = HOLD_CYCLES;
                hold_served++;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Offer one request; starts and ends at a falling edge with tvalid still high
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [7:0] handle);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= handle;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_by_kind[kind]++;
        @(negedge clk);
    endtask

    // Pick one currently live handle at random
    function automatic bit pick_live(output logic [7:0] handle);
        int n;
        int pick;
        n      = $countones(live_handles);
        handle = '0;
        if (n == 0)
            return 1'b0;
        pick = $urandom_range(0, n - 1);
        for (int h = 0; h < POOL_SIZE_DEF; h++)
        begin
            if (live_handles[h])
            begin
                if (pick == 0)
                begin
                    handle = 8'(h);
                    return 1'b1;
                end
                pick--;
            end
        end
        return 1'b0;
    endfunction

    // One random request drawn from a mix; the remainder is noise
    task automatic random_request(input int pct_alloc, input int pct_try, input int pct_rel);
        int         r;
        logic [7:0] h;
        r = $urandom_range(0, 99);
        if (r < pct_alloc)
            send_request(KIND_ALLOC, 8'($urandom));
        else if (r < pct_alloc + pct_try)
            send_request(KIND_TRY, 8'($urandom));
        else if (r < pct_alloc + pct_try + pct_rel)
        begin
            if (pick_live(h))
                send_request(KIND_RELEASE, h);
            else
                send_request(KIND_RELEASE, 8'($urandom));
        end
        else if ($urandom_range(0, 1) == 1)
            send_request(KIND_UNUSED, 8'($urandom));
        else
            send_request(KIND_RELEASE, 8'($urandom));
    endtask

    // Request stimulus and verdict
    initial
    begin
        int n;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        rst_n       = 1'b0;
        steady_flow = 1'b0;
        hold_asked  = 0;
        hold_served = 0;
        idle_cycles = 0;
        foreach (sent_by_kind[k])
            sent_by_kind[k] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty list, never-minted and double releases, unused kind, FIFO reuse
        send_request(KIND_TRY,     8'h00);
        send_request(KIND_RELEASE, 8'h00);
        send_request(KIND_RELEASE, 8'hFF);
        send_request(KIND_UNUSED,  8'hFF);
        send_request(KIND_ALLOC,   8'hFF);
        send_request(KIND_ALLOC,   8'h00);
        send_request(KIND_ALLOC,   8'hA5);
        send_request(KIND_RELEASE, 8'd1);
        send_request(KIND_RELEASE, 8'd1);
        send_request(KIND_TRY,     8'h5A);
        send_request(KIND_RELEASE, 8'd0);
        send_request(KIND_RELEASE, 8'd2);
        send_request(KIND_ALLOC,   8'h00);
        send_request(KIND_ALLOC,   8'h00);
        send_request(KIND_ALLOC,   8'h00);
        send_request(KIND_TRY,     8'hFF);
        send_request(KIND_RELEASE, 8'd3);
        send_request(KIND_RELEASE, 8'd0);
        send_request(KIND_TRY,     8'h00);
        send_request(KIND_UNUSED,  8'h00);

        // Fill the pool until every handle is live; long output stall early on
        n = 0;
        while ($countones(live_handles) < POOL_SIZE_DEF && n < 420)
        begin
            if (n == 40)
                hold_asked++;
            random_request(85, 5, 5);
            n++;
        end
        // Pool exhausted: allocates and tries fail unless a release has freed a handle
        repeat (12) random_request(70, 20, 5);

        // Sender pause until every result is back
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);

        // Drain: mostly releases, with a burst of back-to-back traffic
        for (int i = 0; i < 200; i++)
        begin
            steady_flow = (i >= 80 && i < 120);
            random_request(8, 7, 75);
        end
        steady_flow = 1'b0;

        // Churn: mixed traffic, ring pointers wrap around
        for (int i = 0; i < 170; i++)
        begin
            steady_flow = (i >= 100 && i < 130);
            random_request(35, 10, 50);
        end
        steady_flow = 1'b0;

        // Wind down and wait for the last results
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Sent %0d requests: %0d allocate, %0d try, %0d release, %0d unused kind.",
                 sent_by_kind[0] + sent_by_kind[1] + sent_by_kind[2] + sent_by_kind[3],
                 sent_by_kind[KIND_ALLOC], sent_by_kind[KIND_TRY],
                 sent_by_kind[KIND_RELEASE], sent_by_kind[KIND_UNUSED]);
        $display("Covered pool exhaustion, free-list wrap, a %0d-cycle output stall; %s",
                 HOLD_CYCLES, $sformatf("%0d mismatches.", mismatches));
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/hpool_pkg.sv
rtl/core/hpool_front.sv
rtl/core/hpool_cmdq.sv
rtl/core/hpool_back.sv
rtl/core/fifo_free_list_handle_pool_core.sv
verif/handle_pool_checker.sv
verif/fifo_free_list_handle_pool_core_test.sv
